// ===== src/lfa_pkg.sv =====
// package: luffa-256 constants, types and step functions
package lfa_pkg;

    typedef logic [31:0] t_word;
    typedef t_word t_blk [8];

    // queue entry from front to back: a full block and what follows it
    typedef struct packed {
        logic [255:0] blk;
        logic         fin;
    } t_job;

    localparam logic [767:0] IV = {
        32'h8b264ae7, 32'h24aa230a, 32'h666d1836, 32'h0306194f,
        32'had659c05, 32'h04016ce5, 32'h5dba5781, 32'hf7efc89d,
        32'h746cd581, 32'hcf1ccf0e, 32'h8fc944b3, 32'h5d9b0557,
        32'hde099fa3, 32'h70eee9a0, 32'hd9d2f256, 32'hc3b44b95,
        32'hdef610bb, 32'hee058139, 32'h90152df4, 32'h6e292011,
        32'hdbf78465, 32'h4eaa6fb4, 32'h44b051e0, 32'h6d251e69};

    function automatic t_word step_const(input logic [5:0] i);
        t_word c;
        unique case (i)
            6'd0: c = 32'h303994a6;  6'd1: c = 32'he0337818;
            6'd2: c = 32'hc0e65299;  6'd3: c = 32'h441ba90d;
            6'd4: c = 32'h6cc33a12;  6'd5: c = 32'h7f34d442;
            6'd6: c = 32'hdc56983e;  6'd7: c = 32'h9389217f;
            6'd8: c = 32'h1e00108f;  6'd9: c = 32'he5a8bce6;
            6'd10: c = 32'h7800423d; 6'd11: c = 32'h5274baf4;
            6'd12: c = 32'h8f5b7882; 6'd13: c = 32'h26889ba7;
            6'd14: c = 32'h96e1db12; 6'd15: c = 32'h9a226e9d;
            6'd16: c = 32'hb6de10ed; 6'd17: c = 32'h01685f3d;
            6'd18: c = 32'h70f47aae; 6'd19: c = 32'h05a17cf4;
            6'd20: c = 32'h0707a3d4; 6'd21: c = 32'hbd09caca;
            6'd22: c = 32'h1c1e8f51; 6'd23: c = 32'hf4272b28;
            6'd24: c = 32'h707a3d45; 6'd25: c = 32'h144ae5cc;
            6'd26: c = 32'haeb28562; 6'd27: c = 32'hfaa7ae2b;
            6'd28: c = 32'hbaca1589; 6'd29: c = 32'h2e48f1c1;
            6'd30: c = 32'h40a46f3e; 6'd31: c = 32'hb923c704;
            6'd32: c = 32'hfc20d9d2; 6'd33: c = 32'he25e72c1;
            6'd34: c = 32'h34552e25; 6'd35: c = 32'he623bb72;
            6'd36: c = 32'h7ad8818f; 6'd37: c = 32'h5c58a4a4;
            6'd38: c = 32'h8438764a; 6'd39: c = 32'h1e38e2e7;
            6'd40: c = 32'hbb6de032; 6'd41: c = 32'h78e38b9d;
            6'd42: c = 32'hedb780c8; 6'd43: c = 32'h27586719;
            6'd44: c = 32'hd9847356; 6'd45: c = 32'h36eda57f;
            6'd46: c = 32'ha2c78434; 6'd47: c = 32'h703aace7;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    // multiply by 2 in gf(2^32)^8, word 0 in low bits
    function automatic logic [255:0] gf_dbl(input logic [255:0] v);
        t_word w [8];
        t_word top;
        for (int i = 0; i < 8; i++) w[i] = v[32*i +: 32];
        top = w[7];
        return {w[6], w[5], w[4], w[3] ^ top, w[2] ^ top, w[1], w[0] ^ top, top};
    endfunction

    function automatic logic [127:0] sbox(input t_word a0, input t_word a1,
                                          input t_word a2, input t_word a3);
        t_word s, b0, b1, b2, b3;
        s = a0; b0 = a0; b1 = a1; b2 = a2; b3 = a3;
        b0 = b0 | b1;  b2 = b2 ^ b3;  b1 = ~b1;  b0 = b0 ^ b3;
        b3 = b3 & s;   b1 = b1 ^ b3;  b3 = b3 ^ b2; b2 = b2 & b0;
        b0 = ~b0;      b2 = b2 ^ b1;  b1 = b1 | b3; s = s ^ b1;
        b3 = b3 ^ b2;  b2 = b2 & b1;  b1 = b1 ^ b0; b0 = s;
        return {b3, b2, b1, b0};
    endfunction

    // one step of one sub-block permutation
    function automatic logic [255:0] perm_step(input logic [255:0] v,
                                               input logic [1:0] sub,
                                               input logic [2:0] stp);
        t_word x [8];
        t_word l, r;
        logic [127:0] q;
        for (int i = 0; i < 8; i++) x[i] = v[32*i +: 32];
        q = sbox(x[0], x[1], x[2], x[3]);
        {x[3], x[2], x[1], x[0]} = q;
        q = sbox(x[5], x[6], x[7], x[4]);
        {x[4], x[7], x[6], x[5]} = q;
        for (int k = 0; k < 4; k++) begin
            l = x[k]; r = x[k+4];
            r = r ^ l;
            l = rotl(l, 5'd2) ^ r;
            r = rotl(r, 5'd14) ^ l;
            l = rotl(l, 5'd10) ^ r;
            r = rotl(r, 5'd1);
            x[k] = l; x[k+4] = r;
        end
        x[0] = x[0] ^ step_const({sub, stp, 1'b0});
        x[4] = x[4] ^ step_const({sub, stp, 1'b1});
        return {x[7], x[6], x[5], x[4], x[3], x[2], x[1], x[0]};
    endfunction

endpackage

// ===== src/lfa_front.sv =====
// front end: gathers message words into blocks and appends padding
module lfa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [31:0]   i_word,
    input  logic [5:0]    i_bits,
    input  logic          i_last,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output lfa_pkg::t_job o_job
);
    import lfa_pkg::*;

    logic [255:0] r_blk, n_blk;
    logic [2:0]   r_idx, n_idx;
    logic         r_pad, n_pad;       // extra padding block still owed
    logic         r_jv, n_jv;
    t_job         r_job, n_job;
    logic [5:0]   w_n;
    t_word        w_keep;

    assign o_ready     = !r_jv && !r_pad;
    assign o_job_valid = r_jv;
    assign o_job       = r_job;
    assign w_n = (i_bits > 6'd32) ? 6'd32 : i_bits;
    assign w_keep = (w_n == 6'd0) ? 32'h0 :
        (i_word & ~(32'hffffffff >> w_n[4:0])) | (32'h80000000 >> w_n[4:0]);

    // block assembly and queue entry
    always_comb begin
        n_blk = r_blk; n_idx = r_idx; n_pad = r_pad; n_jv = r_jv; n_job = r_job;
        if (r_jv && i_job_ready) n_jv = 1'b0;
        if (r_pad && !r_jv) begin
            n_job = '{blk: {224'h0, 32'h80000000}, fin: 1'b1};
            n_jv = 1'b1; n_pad = 1'b0;
        end else if (i_valid && o_ready) begin
            if (!i_last || w_n == 6'd32) begin
                n_blk[32*r_idx +: 32] = i_word;
                n_idx = r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    n_job = '{blk: n_blk, fin: 1'b0};
                    n_jv = 1'b1; n_blk = '0;
                    if (i_last) n_pad = 1'b1;
                end else if (i_last) begin
                    n_blk[32*n_idx +: 32] = 32'h80000000;
                    n_job = '{blk: n_blk, fin: 1'b1};
                    n_jv = 1'b1; n_blk = '0; n_idx = '0;
                end
            end else begin
                n_blk[32*r_idx +: 32] = (w_n == 6'd0) ? 32'h80000000 : w_keep;
                n_job = '{blk: n_blk, fin: 1'b1};
                n_jv = 1'b1; n_blk = '0; n_idx = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk <= '0; r_idx <= '0; r_pad <= 1'b0; r_jv <= 1'b0;
        end else begin
            r_blk <= n_blk; r_idx <= n_idx; r_pad <= n_pad; r_jv <= n_jv;
        end
        r_job <= n_job;
    end

`ifndef SYNTHESIS
    a_no_take_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pad |-> !o_ready) else $error("input taken with pad owed");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_jv && !i_job_ready) |=> r_jv && $stable(r_job)) else $error("job lost");
    a_pad_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_pad) |-> r_jv) else $error("pad block missing");
`endif
endmodule

// ===== src/lfa_core.sv =====
// back end: round engine, blank round and digest output
module lfa_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  lfa_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [31:0]   o_word,
    output logic          o_last
);
    import lfa_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_PERM, S_OUT} t_state;
    t_state       r_st;
    logic [767:0] r_cv;
    logic [2:0]   r_stp;
    logic         r_fin, r_blank;
    logic [2:0]   r_oi;
    logic [255:0] w_t, w_m1, w_m2, w_inj;
    logic [767:0] w_step;
    t_word        w_dig [8];

    // no job is taken while the blank round is owed
    assign o_job_ready = (r_st == S_IDLE) && !r_blank;
    assign o_valid     = (r_st == S_OUT);
    assign o_last      = (r_oi == 3'd7);
    assign o_word      = w_dig[r_oi];

    assign w_t  = gf_dbl(r_cv[255:0] ^ r_cv[511:256] ^ r_cv[767:512]);
    assign w_inj = r_blank ? 256'h0 : i_job.blk;
    assign w_m1 = gf_dbl(w_inj);
    assign w_m2 = gf_dbl(w_m1);
    for (genvar g = 0; g < 8; g++) begin : g_dig
        assign w_dig[g] = r_cv[32*g +: 32] ^ r_cv[256+32*g +: 32] ^ r_cv[512+32*g +: 32];
    end
    for (genvar j = 0; j < 3; j++) begin : g_sub
        assign w_step[256*j +: 256] = perm_step(r_cv[256*j +: 256], 2'(j), r_stp);
    end

    // injection then tweak, eight permutation steps, a blank round after the final block, digest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cv <= IV; r_stp <= '0; r_fin <= 1'b0;
            r_blank <= 1'b0; r_oi <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_job_valid || r_blank) begin
                        logic [255:0] c0, c1, c2;
                        c0 = r_cv[255:0] ^ w_t ^ w_inj;
                        c1 = r_cv[511:256] ^ w_t ^ w_m1;
                        c2 = r_cv[767:512] ^ w_t ^ w_m2;
                        for (int k = 4; k < 8; k++) begin
                            c1[32*k +: 32] = rotl(c1[32*k +: 32], 5'd1);
                            c2[32*k +: 32] = rotl(c2[32*k +: 32], 5'd2);
                        end
                        r_cv <= {c2, c1, c0};
                        if (!r_blank) r_fin <= i_job.fin;
                        r_st <= S_PERM; r_stp <= '0;
                    end
                end
                S_PERM: begin
                    r_cv <= w_step;
                    r_stp <= r_stp + 3'd1;
                    if (r_stp == 3'd7) begin
                        if (r_blank) begin
                            r_blank <= 1'b0; r_st <= S_OUT; r_oi <= '0;
                        end else if (r_fin) begin
                            r_blank <= 1'b1; r_fin <= 1'b0; r_st <= S_IDLE;
                        end else r_st <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            r_st <= S_IDLE; r_cv <= IV;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_job_ready) else $error("job taken during output");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> r_st == S_IDLE && !r_blank)
        else $error("digest did not end");
    a_blank_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |-> !r_blank && !r_fin) else $error("stale flags");
`endif
endmodule

// ===== src/luffa256_hash_unit.sv =====
// top level: luffa-256 hash unit, front end, job register, round engine
//  channel | dir | tdata                        | tuser | tlast
//  s_axis  | in  | [31:0] message_word          | [5:0] valid_bits | last_item
//  m_axis  | out | [31:0] digest_word          | -     | digest_last
// one block round is an injection step then eight permutation steps on the
// three sub-blocks in parallel. the last word costs two or three rounds more,
// then eight digest transactions. a one-entry job register between front and
// back lets words gather while a round runs. reset is synchronous; the state
// returns to the iv after each digest.
module luffa256_hash_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // message_word
    input  logic [5:0]  s_axis_tuser,   // valid_bits
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic        m_axis_tlast
);
    import lfa_pkg::*;

    logic jv, jr;
    t_job job;

    lfa_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_word(s_axis_tdata), .i_bits(s_axis_tuser), .i_last(s_axis_tlast),
        .o_job_valid(jv), .i_job_ready(jr), .o_job(job)
    );

    lfa_core u_core (
        .i_clk, .i_rst_n,
        .i_job_valid(jv), .o_job_ready(jr), .i_job(job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_word(m_axis_tdata), .o_last(m_axis_tlast)
    );
endmodule

// ===== tb/sv/luffa256_hash_unit_tb.sv =====
// testbench: luffa-256 hash unit, stream stimulus against a built-in digest predictor
module luffa256_hash_unit_tb;

    typedef logic [31:0] t_word;

    typedef struct {
        t_word word;
        logic  last;
    } t_digest_item;

    localparam t_word INIT_VALUE [24] = '{
        32'h6d251e69, 32'h44b051e0, 32'h4eaa6fb4, 32'hdbf78465,
        32'h6e292011, 32'h90152df4, 32'hee058139, 32'hdef610bb,
        32'hc3b44b95, 32'hd9d2f256, 32'h70eee9a0, 32'hde099fa3,
        32'h5d9b0557, 32'h8fc944b3, 32'hcf1ccf0e, 32'h746cd581,
        32'hf7efc89d, 32'h5dba5781, 32'h04016ce5, 32'had659c05,
        32'h0306194f, 32'h666d1836, 32'h24aa230a, 32'h8b264ae7};

    localparam t_word ROUND_CONST [48] = '{
        32'h303994a6, 32'he0337818, 32'hc0e65299, 32'h441ba90d,
        32'h6cc33a12, 32'h7f34d442, 32'hdc56983e, 32'h9389217f,
        32'h1e00108f, 32'he5a8bce6, 32'h7800423d, 32'h5274baf4,
        32'h8f5b7882, 32'h26889ba7, 32'h96e1db12, 32'h9a226e9d,
        32'hb6de10ed, 32'h01685f3d, 32'h70f47aae, 32'h05a17cf4,
        32'h0707a3d4, 32'hbd09caca, 32'h1c1e8f51, 32'hf4272b28,
        32'h707a3d45, 32'h144ae5cc, 32'haeb28562, 32'hfaa7ae2b,
        32'hbaca1589, 32'h2e48f1c1, 32'h40a46f3e, 32'hb923c704,
        32'hfc20d9d2, 32'he25e72c1, 32'h34552e25, 32'he623bb72,
        32'h7ad8818f, 32'h5c58a4a4, 32'h8438764a, 32'h1e38e2e7,
        32'hbb6de032, 32'h78e38b9d, 32'hedb780c8, 32'h27586719,
        32'hd9847356, 32'h36eda57f, 32'ha2c78434, 32'h703aace7};

    // predictor of the hash state plus queue of pending digest words
    class digest_scoreboard;
        t_word        chain [24];
        t_word        blk [8];
        int unsigned  fill_words;
        t_digest_item pending [$];
        int           errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            chain = INIT_VALUE;
            foreach (blk[i]) blk[i] = '0;
            fill_words = 0;
        endfunction

        function t_word rol(t_word x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void times_two(ref t_word v [8]);
            t_word top;
            top = v[7];
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] ^ top; v[3] = v[2] ^ top;
            v[2] = v[1]; v[1] = v[0] ^ top; v[0] = top;
        endfunction

        function void sub_crumb(ref t_word a0, ref t_word a1, ref t_word a2, ref t_word a3);
            t_word s;
            s = a0;
            a0 |= a1; a2 ^= a3; a1 = ~a1; a0 ^= a3;
            a3 &= s; a1 ^= a3; a3 ^= a2; a2 &= a0;
            a0 = ~a0; a2 ^= a1; a1 |= a3; s ^= a1;
            a3 ^= a2; a2 &= a1; a1 ^= a0; a0 = s;
        endfunction

        function void permute_sub(int sub);
            t_word x [8];
            t_word l, r;
            for (int k = 0; k < 8; k++) x[k] = chain[8*sub + k];
            if (sub != 0)
                for (int k = 4; k < 8; k++) x[k] = rol(x[k], sub);
            for (int s = 0; s < 8; s++) begin
                sub_crumb(x[0], x[1], x[2], x[3]);
                sub_crumb(x[5], x[6], x[7], x[4]);
                for (int k = 0; k < 4; k++) begin
                    l = x[k]; r = x[k+4];
                    r ^= l;
                    l = rol(l, 2) ^ r;
                    r = rol(r, 14) ^ l;
                    l = rol(l, 10) ^ r;
                    r = rol(r, 1);
                    x[k] = l; x[k+4] = r;
                end
                x[0] ^= ROUND_CONST[16*sub + 2*s];
                x[4] ^= ROUND_CONST[16*sub + 2*s + 1];
            end
            for (int k = 0; k < 8; k++) chain[8*sub + k] = x[k];
        endfunction

        function void mix_block();
            t_word t [8];
            t_word m [8];
            for (int i = 0; i < 8; i++) begin
                t[i] = chain[i] ^ chain[i+8] ^ chain[i+16];
                m[i] = blk[i];
            end
            times_two(t);
            for (int j = 0; j < 3; j++) begin
                for (int i = 0; i < 8; i++) chain[8*j + i] ^= t[i] ^ m[i];
                times_two(m);
            end
            for (int j = 0; j < 3; j++) permute_sub(j);
            foreach (blk[i]) blk[i] = '0;
            fill_words = 0;
        endfunction

        function void absorb(t_word w);
            blk[fill_words] = w;
            fill_words++;
            if (fill_words == 8) mix_block();
        endfunction

        // note one accepted message transaction
        function void note_word(t_word w, logic [5:0] nbits, logic fin);
            int unsigned n;
            int unsigned idx;
            t_word keep;
            t_digest_item d;
            if (!fin) begin
                absorb(w);
                return;
            end
            n = (nbits > 32) ? 32 : nbits;
            if (n == 32) begin
                absorb(w);
                idx = fill_words;
                blk[idx] = 32'h80000000;
            end else begin
                keep = (n == 0) ? '0 : (w & (32'hffffffff << (32 - n)));
                idx = fill_words;
                blk[idx] = keep | (32'h80000000 >> n);
            end
            for (int i = idx + 1; i < 8; i++) blk[i] = '0;
            mix_block();
            mix_block();
            for (int i = 0; i < 8; i++) begin
                d.word = chain[i] ^ chain[i+8] ^ chain[i+16];
                d.last = (i == 7);
                pending.push_back(d);
            end
            clear_state();
        endfunction

        // check one digest transaction against the oldest expectation
        function void check_digest(t_word w, logic fin);
            t_digest_item d;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected digest word %h last %b", w, fin);
                return;
            end
            d = pending.pop_front();
            if (d.word !== w || d.last !== fin) begin
                errors++;
                if (errors <= 10)
                    $display("digest mismatch: expected %h/%b got %h/%b",
                             d.word, d.last, w, fin);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // message_word
    logic [5:0]  s_axis_tuser;   // valid_bits
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // digest_word
    logic        m_axis_tlast;

    digest_scoreboard sb;
    logic        stall_enable;
    int          cycles;

    luffa256_hash_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("luffa256_hash_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // receiver: random stall bursts while enabled
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (stall_enable && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // monitor digest transactions
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_digest(m_axis_tdata, m_axis_tlast);
    end

    // one message transaction, with an optional idle burst ahead of it
    task automatic send_word(input t_word w, input logic [5:0] nbits, input logic fin);
        int gap;
        if (stall_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= nbits;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_word(w, nbits, fin);
    endtask

    task automatic send_message(input int unsigned nwords, input logic [5:0] nbits);
        for (int unsigned i = 0; i < nwords; i++)
            send_word($urandom, 6'($urandom_range(0, 63)), 1'b0);
        send_word($urandom, nbits, 1'b1);
    endtask

    initial begin
        int sent;
        int unsigned nw;
        logic [5:0] nb;
        sb = new();
        stall_enable  = 1'b1;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message, extreme words, bit counts around the edges
        send_word(32'h00000000, 6'd0, 1'b1);
        send_word(32'hffffffff, 6'd32, 1'b1);
        send_word(32'hffffffff, 6'd63, 1'b1);
        send_word(32'hffffffff, 6'd1, 1'b1);
        send_word(32'hffffffff, 6'd31, 1'b1);
        send_word(32'h00000000, 6'd33, 1'b1);
        // final word filling a block exactly, then one landing at a block start
        for (int i = 0; i < 7; i++) send_word(32'ha5a5a5a5, 6'd0, 1'b0);
        send_word(32'h5a5a5a5a, 6'd32, 1'b1);
        for (int i = 0; i < 8; i++) send_word(32'hffffffff, 6'd63, 1'b0);
        send_word(32'h12345678, 6'd17, 1'b1);

        // hold off until every digest word is back
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);

        // random messages, mostly short, a few several blocks long
        sent = 0;
        while (sent < 180) begin
            if (sent > 130) stall_enable = 1'b0;
            nw = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 9);
            case ($urandom_range(0, 3))
                0: nb = 6'd32;
                1: nb = 6'($urandom_range(33, 63));
                default: nb = 6'($urandom_range(0, 31));
            endcase
            send_message(nw, nb);
            sent += nw + 1;
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0)
            $display("luffa256_hash_unit_tb: PASS");
        else
            $display("luffa256_hash_unit_tb: FAIL");
        $finish;
    end

endmodule
